// File: rtl/gpf_pkg.sv
// Shared constants and types of the pairwise gravity force pipeline.
package gpf_pkg;

    // Digit width of the partial-product multipliers.
    localparam int DIG_W = 32;
    localparam int PP_W  = 2 * DIG_W;

    // Register widths.
    localparam int GRAV_W    = 32;
    localparam int SHIFT_W   = 6;
    localparam int SHIFT_MAX = (1 << SHIFT_W) - 1;

    // Result component width, square-root width and quotient width.
    localparam int OUT_W = 64;
    localparam int RB    = OUT_W - 1;
    localparam int QB    = 2 * RB;

    // Configuration port.
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    typedef enum logic {
        REG_GRAV  = 1'b0,
        REG_SHIFT = 1'b1
    } cfg_reg_t;

    // Bit positions in the result tuser.
    localparam int TUSER_COIN = 0;
    localparam int TUSER_SAT  = 1;
    localparam int TUSER_W    = 2;

    // Clamped component values.
    localparam logic [OUT_W-1:0] FORCE_SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] FORCE_SAT_NEG = {1'b1, {(OUT_W-2){1'b0}}, 1'b1};

    // Per-item flags that ride along the pipeline.
    typedef struct packed {
        logic sx;
        logic sy;
        logic coin;
    } pair_flags_t;

endpackage

// File: rtl/gpf_mul.sv
// Pipelined unsigned multiplier built from one 32x32 partial product per stage.
module gpf_mul
    import gpf_pkg::*;
#(
    parameter int A_W    = 32,
    parameter int B_W    = 32,
    parameter int SIDE_W = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [A_W-1:0]       a,
    input  logic [B_W-1:0]       b,
    input  logic [SIDE_W-1:0]    side_in,
    output logic                 out_valid,
    output logic [A_W+B_W-1:0]   p,
    output logic [SIDE_W-1:0]    side_out
);

    localparam int NA    = (A_W + DIG_W - 1) / DIG_W;
    localparam int NB    = (B_W + DIG_W - 1) / DIG_W;
    localparam int NP    = NA * NB;
    localparam int AP_W  = NA * DIG_W;
    localparam int BP_W  = NB * DIG_W;
    localparam int ACC_W = AP_W + BP_W;

    logic              vld_reg  [0:NP];
    logic [AP_W-1:0]   a_reg    [0:NP-1];
    logic [BP_W-1:0]   b_reg    [0:NP-1];
    logic [ACC_W-1:0]  acc_reg  [1:NP];
    logic [SIDE_W-1:0] side_reg [0:NP];

    // Operand register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg[0]    <= AP_W'(a);
            b_reg[0]    <= BP_W'(b);
            side_reg[0] <= side_in;
        end
    end

    // One partial product is added to the running sum in each stage.
    for (genvar k = 0; k < NP; k++) begin : g_stage
        localparam int I = k / NB;
        localparam int J = k % NB;
        logic [PP_W-1:0]  pp;
        logic [ACC_W-1:0] acc_next;

        always_comb begin
            pp = PP_W'(a_reg[k][I*DIG_W +: DIG_W]) * PP_W'(b_reg[k][J*DIG_W +: DIG_W]);
        end

        if (k == 0) begin : g_first
            assign acc_next = ACC_W'(pp) << (DIG_W * (I + J));
        end else begin : g_rest
            assign acc_next = acc_reg[k] + (ACC_W'(pp) << (DIG_W * (I + J)));
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                acc_reg[k+1]  <= acc_next;
                side_reg[k+1] <= side_reg[k];
            end
        end

        if (k + 1 < NP) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    a_reg[k+1] <= a_reg[k];
                    b_reg[k+1] <= b_reg[k];
                end
            end
        end
    end

    assign out_valid = vld_reg[NP];
    assign p         = acc_reg[NP][A_W+B_W-1:0];
    assign side_out  = side_reg[NP];

endmodule

// File: rtl/gravity_pair_force.sv
// Pairwise 2D gravitational force pipeline: one body pair per clock unless the result side stalls.
//
// gravity_pair_force takes one word per clock holding the positions and masses
// of two bodies and returns, for each word, the x and y force on body A from
// body B, G*ma*mb*d/R^3 shifted right by result_shift, computed exactly as the
// floor of the magnitude with the sign of the separation. A magnitude of 2^63
// or more is clamped to 2^63-1 and flagged as saturated; coincident bodies give
// zero force and the coincident flag. The pipeline accepts a new word in every
// cycle while the result side keeps taking words; most of its depth lies in
// the restoring division (127 stages) and square root (63 stages) that follow
// the chain of 32x32 partial-product multipliers. The whole pipeline advances
// together, so a stall on the result side holds every stage, and nothing is
// lost or repeated. Registers must be written only while the pipeline is empty.
module gravity_pair_force
    import gpf_pkg::*;
#(
    parameter int POS_WIDTH  = 32,
    parameter int MASS_WIDTH = 32,
    localparam int IN_W      = 4 * POS_WIDTH + 2 * MASS_WIDTH,
    localparam int IN_TW     = ((IN_W + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input words.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pos_x_a, pos_y_a, mass_a, pos_x_b, pos_y_b, mass_b (lowest bits first)
    input  logic [IN_TW-1:0]      s_tdata,
    // Result words.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // force_x, force_y (lowest bits first)
    output logic [2*OUT_W-1:0]    m_tdata,
    // coincident, saturated (lowest bit first)
    output logic [TUSER_W-1:0]    m_tuser,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int DW    = POS_WIDTH + 1;
    localparam int P1W   = 2 * MASS_WIDTH;
    localparam int GMW   = P1W + GRAV_W;
    localparam int NW    = GMW + DW;
    localparam int AW    = 2 * NW;
    localparam int SQD   = 2 * DW;
    localparam int R2W   = SQD + 1;
    localparam int SQW   = 2 * R2W;
    localparam int CUBEW = 3 * R2W;
    localparam int CW    = CUBEW + 2 * SHIFT_MAX;
    localparam int YW    = AW + CW;
    localparam int FL_W  = $bits(pair_flags_t);
    localparam int S1W   = 2 * DW + FL_W;
    localparam int TW    = QB + 1;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [GRAV_W-1:0]  grav_constant_reg;
    logic [SHIFT_W-1:0] result_shift_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_constant_reg <= GRAV_W'(1);
            result_shift_reg  <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_reg_t'(paddr[2]))
                REG_GRAV:  grav_constant_reg <= pwdata[GRAV_W-1:0];
                REG_SHIFT: result_shift_reg  <= pwdata[SHIFT_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_reg_t'(paddr[2]))
            REG_GRAV:  prdata = CFG_DATA_W'(grav_constant_reg);
            REG_SHIFT: prdata = CFG_DATA_W'(result_shift_reg);
        endcase
    end

    // ------------------------------------------------------------------
    // Global advance: every stage moves when the output register is free.
    // ------------------------------------------------------------------
    logic en;
    logic m_tvalid_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // ------------------------------------------------------------------
    // Separation and its magnitude.
    // ------------------------------------------------------------------
    logic [POS_WIDTH-1:0]  pos_x_a, pos_y_a, pos_x_b, pos_y_b;
    logic [MASS_WIDTH-1:0] mass_a, mass_b;

    assign pos_x_a = s_tdata[0 +: POS_WIDTH];
    assign pos_y_a = s_tdata[POS_WIDTH +: POS_WIDTH];
    assign mass_a  = s_tdata[2*POS_WIDTH +: MASS_WIDTH];
    assign pos_x_b = s_tdata[2*POS_WIDTH+MASS_WIDTH +: POS_WIDTH];
    assign pos_y_b = s_tdata[3*POS_WIDTH+MASS_WIDTH +: POS_WIDTH];
    assign mass_b  = s_tdata[4*POS_WIDTH+MASS_WIDTH +: MASS_WIDTH];

    logic                  v1_reg, v2_reg;
    logic [DW-1:0]         dx_reg, dy_reg, dx_next, dy_next;
    logic [MASS_WIDTH-1:0] ma_reg, mb_reg, ma2_reg, mb2_reg;
    logic [DW-1:0]         ax_reg, ay_reg, ax_next, ay_next;
    pair_flags_t           fl2_reg, fl2_next;

    assign dx_next = {pos_x_b[POS_WIDTH-1], pos_x_b} - {pos_x_a[POS_WIDTH-1], pos_x_a};
    assign dy_next = {pos_y_b[POS_WIDTH-1], pos_y_b} - {pos_y_a[POS_WIDTH-1], pos_y_a};

    always_comb begin
        ax_next       = dx_reg[DW-1] ? (DW'(0) - dx_reg) : dx_reg;
        ay_next       = dy_reg[DW-1] ? (DW'(0) - dy_reg) : dy_reg;
        fl2_next.sx   = dx_reg[DW-1];
        fl2_next.sy   = dy_reg[DW-1];
        fl2_next.coin = (dx_reg == '0) && (dy_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            ma_reg  <= mass_a;
            mb_reg  <= mass_b;
            ax_reg  <= ax_next;
            ay_reg  <= ay_next;
            fl2_reg <= fl2_next;
            ma2_reg <= ma_reg;
            mb2_reg <= mb_reg;
        end
    end

    // ------------------------------------------------------------------
    // Multiplier chain. Values not used by a multiplier ride in its side bus.
    // ------------------------------------------------------------------
    logic             v_m1, v_m2, v_m3, v_m4, v_m5, v_m6, v_m7, v_m8, v_m9, v_m10;
    logic [P1W-1:0]   p_m1;
    logic [S1W-1:0]   s_m1, s_m2;
    logic [GMW-1:0]   p_m2;
    logic [NW-1:0]    p_m3, p_m4;
    logic [GMW+S1W-1:0] s_m3;
    logic [NW+S1W-1:0]  s_m4;
    logic [SQD-1:0]   p_m5, p_m6;
    logic [2*NW+S1W-1:0] s_m5;
    logic [SQD+2*NW+FL_W-1:0] s_m6;
    logic [R2W-1:0]   r2;
    logic [SQW-1:0]   p_m7;
    logic [R2W+2*NW+FL_W-1:0] s_m7;
    logic [CUBEW-1:0] p_m8;
    logic [2*NW+FL_W-1:0] s_m8;
    logic [AW-1:0]    p_m9, p_m10;
    logic [NW+CUBEW+FL_W-1:0] s_m9;
    logic [AW+CUBEW+FL_W-1:0] s_m10;

    // mass_a * mass_b
    gpf_mul #(.A_W(MASS_WIDTH), .B_W(MASS_WIDTH), .SIDE_W(S1W)) u_m1 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v2_reg),
        .a(ma2_reg), .b(mb2_reg), .side_in({ax_reg, ay_reg, fl2_reg}),
        .out_valid(v_m1), .p(p_m1), .side_out(s_m1)
    );

    // G * mass_a * mass_b
    gpf_mul #(.A_W(P1W), .B_W(GRAV_W), .SIDE_W(S1W)) u_m2 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v_m1),
        .a(p_m1), .b(grav_constant_reg), .side_in(s_m1),
        .out_valid(v_m2), .p(p_m2), .side_out(s_m2)
    );

    // Numerator of the x component.
    gpf_mul #(.A_W(GMW), .B_W(DW), .SIDE_W(GMW+S1W)) u_m3 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v_m2),
        .a(p_m2), .b(s_m2[FL_W+DW +: DW]), .side_in({p_m2, s_m2}),
        .out_valid(v_m3), .p(p_m3), .side_out(s_m3)
    );

    // Numerator of the y component.
    gpf_mul #(.A_W(GMW), .B_W(DW), .SIDE_W(NW+S1W)) u_m4 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v_m3),
        .a(s_m3[S1W +: GMW]), .b(s_m3[FL_W +: DW]), .side_in({p_m3, s_m3[S1W-1:0]}),
        .out_valid(v_m4), .p(p_m4), .side_out(s_m4)
    );

    // dx squared.
    gpf_mul #(.A_W(DW), .B_W(DW), .SIDE_W(2*NW+S1W)) u_m5 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v_m4),
        .a(s_m4[FL_W+DW +: DW]), .b(s_m4[FL_W+DW +: DW]),
        .side_in({s_m4[S1W +: NW], p_m4, s_m4[S1W-1:0]}),
        .out_valid(v_m5), .p(p_m5), .side_out(s_m5)
    );

    // dy squared.
    gpf_mul #(.A_W(DW), .B_W(DW), .SIDE_W(SQD+2*NW+FL_W)) u_m6 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v_m5),
        .a(s_m5[FL_W +: DW]), .b(s_m5[FL_W +: DW]),
        .side_in({p_m5, s_m5[S1W +: 2*NW], s_m5[FL_W-1:0]}),
        .out_valid(v_m6), .p(p_m6), .side_out(s_m6)
    );

    // Squared distance, added on the way into the next operand register.
    assign r2 = R2W'(s_m6[FL_W+2*NW +: SQD]) + R2W'(p_m6);

    // R^2 squared.
    gpf_mul #(.A_W(R2W), .B_W(R2W), .SIDE_W(R2W+2*NW+FL_W)) u_m7 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v_m6),
        .a(r2), .b(r2), .side_in({r2, s_m6[2*NW+FL_W-1:0]}),
        .out_valid(v_m7), .p(p_m7), .side_out(s_m7)
    );

    // R^2 cubed.
    gpf_mul #(.A_W(SQW), .B_W(R2W), .SIDE_W(2*NW+FL_W)) u_m8 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v_m7),
        .a(p_m7), .b(s_m7[FL_W+2*NW +: R2W]), .side_in(s_m7[2*NW+FL_W-1:0]),
        .out_valid(v_m8), .p(p_m8), .side_out(s_m8)
    );

    // Squared x numerator.
    gpf_mul #(.A_W(NW), .B_W(NW), .SIDE_W(NW+CUBEW+FL_W)) u_m9 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v_m8),
        .a(s_m8[FL_W+NW +: NW]), .b(s_m8[FL_W+NW +: NW]),
        .side_in({s_m8[FL_W +: NW], p_m8, s_m8[FL_W-1:0]}),
        .out_valid(v_m9), .p(p_m9), .side_out(s_m9)
    );

    // Squared y numerator.
    gpf_mul #(.A_W(NW), .B_W(NW), .SIDE_W(AW+CUBEW+FL_W)) u_m10 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v_m9),
        .a(s_m9[FL_W+CUBEW +: NW]), .b(s_m9[FL_W+CUBEW +: NW]),
        .side_in({p_m9, s_m9[CUBEW+FL_W-1:0]}),
        .out_valid(v_m10), .p(p_m10), .side_out(s_m10)
    );

    // ------------------------------------------------------------------
    // Restoring division of the squared numerators by R^6 * 4^shift.
    // The top quotient bit, bit 126, means the component saturates.
    // ------------------------------------------------------------------
    logic            dvld_reg [0:QB+1];
    logic [QB:0]     dqx_reg  [0:QB+1];
    logic [QB:0]     dqy_reg  [0:QB+1];
    pair_flags_t     dfl_reg  [0:QB+1];
    logic [AW-1:0]   drx_reg  [0:QB];
    logic [AW-1:0]   dry_reg  [0:QB];
    logic [CW-1:0]   dc_reg   [0:QB];
    logic [CW-1:0]   dc_next;

    assign dc_next = CW'(s_m10[FL_W +: CUBEW]) << {result_shift_reg, 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dvld_reg[0] <= 1'b0;
        end else if (en) begin
            dvld_reg[0] <= v_m10;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dqx_reg[0] <= '0;
            dqy_reg[0] <= '0;
            dfl_reg[0] <= pair_flags_t'(s_m10[FL_W-1:0]);
            drx_reg[0] <= s_m10[FL_W+CUBEW +: AW];
            dry_reg[0] <= p_m10;
            dc_reg[0]  <= dc_next;
        end
    end

    for (genvar k = 0; k <= QB; k++) begin : g_div
        localparam int SH = QB - k;
        logic [YW-1:0] cs, ext_x, ext_y, dif_x, dif_y;
        logic          ge_x, ge_y;

        always_comb begin
            cs    = YW'(dc_reg[k]) << SH;
            ext_x = YW'(drx_reg[k]);
            ext_y = YW'(dry_reg[k]);
            ge_x  = ext_x >= cs;
            ge_y  = ext_y >= cs;
            dif_x = ext_x - cs;
            dif_y = ext_y - cs;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dvld_reg[k+1] <= 1'b0;
            end else if (en) begin
                dvld_reg[k+1] <= dvld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dqx_reg[k+1] <= {dqx_reg[k][QB-1:0], ge_x};
                dqy_reg[k+1] <= {dqy_reg[k][QB-1:0], ge_y};
                dfl_reg[k+1] <= dfl_reg[k];
            end
        end

        if (k < QB) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    drx_reg[k+1] <= ge_x ? dif_x[AW-1:0] : drx_reg[k];
                    dry_reg[k+1] <= ge_y ? dif_y[AW-1:0] : dry_reg[k];
                    dc_reg[k+1]  <= dc_reg[k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Restoring integer square root of the 126-bit quotients.
    // ------------------------------------------------------------------
    logic            qvld_reg [1:RB];
    logic [RB-1:0]   qtx_reg  [1:RB];
    logic [RB-1:0]   qty_reg  [1:RB];
    logic            qsx_reg  [1:RB];
    logic            qsy_reg  [1:RB];
    pair_flags_t     qfl_reg  [1:RB];
    logic [QB-1:0]   qrx_reg  [1:RB-1];
    logic [QB-1:0]   qry_reg  [1:RB-1];

    for (genvar k = 0; k < RB; k++) begin : g_sqrt
        localparam int J = RB - 1 - k;
        logic          cur_vld, cur_sx, cur_sy;
        logic [RB-1:0] cur_tx, cur_ty;
        logic [QB-1:0] cur_rx, cur_ry;
        pair_flags_t   cur_fl;
        logic [TW-1:0] trial_x, trial_y, dif_x, dif_y;
        logic          ge_x, ge_y;

        if (k == 0) begin : g_src_div
            assign cur_vld = dvld_reg[QB+1];
            assign cur_sx  = dqx_reg[QB+1][QB];
            assign cur_sy  = dqy_reg[QB+1][QB];
            assign cur_rx  = dqx_reg[QB+1][QB-1:0];
            assign cur_ry  = dqy_reg[QB+1][QB-1:0];
            assign cur_tx  = '0;
            assign cur_ty  = '0;
            assign cur_fl  = dfl_reg[QB+1];
        end else begin : g_src_prev
            assign cur_vld = qvld_reg[k];
            assign cur_sx  = qsx_reg[k];
            assign cur_sy  = qsy_reg[k];
            assign cur_rx  = qrx_reg[k];
            assign cur_ry  = qry_reg[k];
            assign cur_tx  = qtx_reg[k];
            assign cur_ty  = qty_reg[k];
            assign cur_fl  = qfl_reg[k];
        end

        // (root + 2^J)^2 fits when the remainder covers root*2^(J+1) + 4^J.
        always_comb begin
            trial_x = (TW'(cur_tx) << (J + 1)) | (TW'(1) << (2 * J));
            trial_y = (TW'(cur_ty) << (J + 1)) | (TW'(1) << (2 * J));
            ge_x    = TW'(cur_rx) >= trial_x;
            ge_y    = TW'(cur_ry) >= trial_y;
            dif_x   = TW'(cur_rx) - trial_x;
            dif_y   = TW'(cur_ry) - trial_y;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                qvld_reg[k+1] <= 1'b0;
            end else if (en) begin
                qvld_reg[k+1] <= cur_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                qtx_reg[k+1] <= cur_tx | (RB'(ge_x) << J);
                qty_reg[k+1] <= cur_ty | (RB'(ge_y) << J);
                qsx_reg[k+1] <= cur_sx;
                qsy_reg[k+1] <= cur_sy;
                qfl_reg[k+1] <= cur_fl;
            end
        end

        if (k + 1 < RB) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    qrx_reg[k+1] <= ge_x ? dif_x[QB-1:0] : cur_rx;
                    qry_reg[k+1] <= ge_y ? dif_y[QB-1:0] : cur_ry;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sign, clamping and the coincident case; output register.
    // ------------------------------------------------------------------
    logic [OUT_W-1:0]   mag_x, mag_y, fx_next, fy_next;
    logic [TUSER_W-1:0] user_next;
    logic [2*OUT_W-1:0] m_tdata_reg;
    logic [TUSER_W-1:0] m_tuser_reg;
    pair_flags_t        fin_fl;

    assign fin_fl = qfl_reg[RB];

    always_comb begin
        mag_x     = qsx_reg[RB] ? FORCE_SAT_POS : {1'b0, qtx_reg[RB]};
        mag_y     = qsy_reg[RB] ? FORCE_SAT_POS : {1'b0, qty_reg[RB]};
        fx_next   = fin_fl.sx ? (OUT_W'(0) - mag_x) : mag_x;
        fy_next   = fin_fl.sy ? (OUT_W'(0) - mag_y) : mag_y;
        user_next = '0;
        if (fin_fl.coin) begin
            fx_next               = '0;
            fy_next               = '0;
            user_next[TUSER_COIN] = 1'b1;
        end else begin
            user_next[TUSER_SAT] = qsx_reg[RB] || qsy_reg[RB];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= qvld_reg[RB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {fy_next, fx_next};
            m_tuser_reg <= user_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_coin_not_sat : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[TUSER_COIN] && m_tuser[TUSER_SAT]))
        else $error("coincident and saturated set on the same word");

    a_coin_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[TUSER_COIN]) |-> (m_tdata == '0))
        else $error("coincident word carries nonzero force");

    a_sat_clamped : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[TUSER_SAT]) |->
            ((m_tdata[OUT_W-1:0] == FORCE_SAT_POS) ||
             (m_tdata[OUT_W-1:0] == FORCE_SAT_NEG) ||
             (m_tdata[2*OUT_W-1:OUT_W] == FORCE_SAT_POS) ||
             (m_tdata[2*OUT_W-1:OUT_W] == FORCE_SAT_NEG)))
        else $error("saturated word without a clamped component");

endmodule

// File: sim/gpf_checker.sv
// Checker for the pair force pipeline: predicts each result word and compares it.
module gpf_checker
    import gpf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [191:0]          s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [2*OUT_W-1:0]    m_tdata,
    input  logic [TUSER_W-1:0]    m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    errors,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [OUT_W-1:0] fx;
        logic [OUT_W-1:0] fy;
        logic             coin;
        logic             sat;
    } force_t;

    logic [GRAV_W-1:0]  grav_q;
    logic [SHIFT_W-1:0] shift_q;
    force_t             force_fifo[$];

    // True when (q << sh)^2 * cube stays at or below num2.
    function automatic logic fits(logic [63:0] q, logic [SHIFT_W-1:0] sh,
                                  logic [511:0] cube, logic [511:0] num2);
        logic [511:0] t;
        t = {448'd0, q} << sh;
        t = t * t;
        t = t * cube;
        return t <= num2;
    endfunction

    // Floor of gmm*|d| / (R^3 * 2^sh), clamped to 2^63-1.
    function automatic logic [63:0] magnitude(logic [63:0] dabs, logic [511:0] gmm,
                                              logic [511:0] cube,
                                              logic [SHIFT_W-1:0] sh, ref logic sat);
        logic [511:0] num;
        logic [63:0]  q;
        num = gmm * {448'd0, dabs};
        num = num * num;
        q = 0;
        if (fits(64'h8000_0000_0000_0000, sh, cube, num)) begin
            sat = 1'b1;
            return 64'h7FFF_FFFF_FFFF_FFFF;
        end
        for (int b = 62; b >= 0; b--) begin
            if (fits(q | (64'd1 << b), sh, cube, num))
                q = q | (64'd1 << b);
        end
        return q;
    endfunction

    function automatic force_t predict_force(logic [191:0] w);
        force_t       f;
        logic signed [63:0] dx, dy;
        logic [63:0]  ax, ay, mx, my;
        logic [511:0] gmm, r2, cube;
        logic         sat;
        dx = $signed(w[127:96]) - $signed(w[31:0]);
        dy = $signed(w[159:128]) - $signed(w[63:32]);
        f = '0;
        if (dx == 0 && dy == 0) begin
            f.coin = 1'b1;
            return f;
        end
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        gmm = {480'd0, grav_q};
        gmm = gmm * {480'd0, w[95:64]};
        gmm = gmm * {480'd0, w[191:160]};
        r2 = {448'd0, ax} * {448'd0, ax} + {448'd0, ay} * {448'd0, ay};
        cube = r2 * r2 * r2;
        sat = 1'b0;
        mx = magnitude(ax, gmm, cube, shift_q, sat);
        my = magnitude(ay, gmm, cube, shift_q, sat);
        f.fx = dx < 0 ? -mx : mx;
        f.fy = dy < 0 ? -my : my;
        f.sat = sat;
        return f;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    initial errors = 0;
    assign pending = force_fifo.size();

    always @(posedge aclk) begin
        force_t want;
        if (!aresetn) begin
            grav_q  <= GRAV_W'(1);
            shift_q <= '0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
                if (cfg_reg_t'(paddr[2]) == REG_GRAV)
                    grav_q <= pwdata[GRAV_W-1:0];
                else
                    shift_q <= pwdata[SHIFT_W-1:0];
            end
            if (s_tvalid && s_tready)
                force_fifo.push_back(predict_force(s_tdata));
            if (m_tvalid && m_tready) begin
                if (force_fifo.size() == 0) begin
                    report("unexpected word", m_tdata[63:0], 64'd0);
                end else begin
                    want = force_fifo.pop_front();
                    if (m_tdata[OUT_W-1:0] !== want.fx)
                        report("force_x", m_tdata[OUT_W-1:0], want.fx);
                    if (m_tdata[2*OUT_W-1:OUT_W] !== want.fy)
                        report("force_y", m_tdata[2*OUT_W-1:OUT_W], want.fy);
                    if (m_tuser[TUSER_COIN] !== want.coin)
                        report("coincident", 64'(m_tuser[TUSER_COIN]), 64'(want.coin));
                    if (m_tuser[TUSER_SAT] !== want.sat)
                        report("saturated", 64'(m_tuser[TUSER_SAT]), 64'(want.sat));
                end
            end
        end
    end
endmodule

// File: sim/testbench.sv
// Top of the pair force testbench: stimulus, configuration phases and verdict.
module testbench
    import gpf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // pos_x_a, pos_y_a, mass_a, pos_x_b, pos_y_b, mass_b (lowest bits first)
    logic [191:0]          s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // force_x, force_y (lowest bits first)
    logic [2*OUT_W-1:0]    m_tdata;
    // coincident, saturated (lowest bit first)
    logic [TUSER_W-1:0]    m_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int errors;
    int pending;
    // The final phase runs with both sides always ready.
    bit quiet = 1'b0;
    // Set by the stimulus to ask the receiver for one long hold-off.
    bit hold_req = 1'b0;

    always #5 aclk = ~aclk;

    gravity_pair_force uut (.*);

    gpf_checker chk (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .errors, .pending
    );

    // A register write: a setup phase, then an access phase.
    task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Offers one word and waits until the block has taken it. A random gap may
    // follow, during which tvalid is low.
    task automatic send_pair(logic [31:0] xa, logic [31:0] ya, logic [31:0] ma,
                             logic [31:0] xb, logic [31:0] yb, logic [31:0] mb);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {mb, yb, xb, ma, ya, xa};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Random pair. Half of the pairs are close together so that forces are not
    // floored away to zero; the rest are fully random or degenerate.
    task automatic send_random;
        logic [31:0] xa, ya, xb, yb, ma, mb;
        int mode, k;
        xa = $urandom; ya = $urandom; ma = $urandom;
        xb = $urandom; yb = $urandom; mb = $urandom;
        mode = $urandom_range(0, 9);
        k = $urandom_range(0, 31);
        if (mode >= 2 && mode <= 6) begin
            xb = xa + ($urandom >> k) - ($urandom >> k);
            yb = ya + ($urandom >> k) - ($urandom >> k);
        end else if (mode == 7) begin
            xb = xa;
            yb = ya;
        end else if (mode == 8) begin
            if ($urandom_range(0, 1)) begin
                xb = xa;
                yb = ya + ($urandom >> k);
            end else begin
                yb = ya;
                xb = xa - ($urandom >> k);
            end
        end
        send_pair(xa, ya, ma, xb, yb, mb);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    // Receiver: random bursts of stall, one long hold-off on request, and
    // always ready in the quiet phase.
    initial begin
        forever begin
            if (hold_req && !quiet) begin
                m_tready <= 1'b0;
                repeat (800) @(posedge aclk);
                hold_req = 1'b0;
            end else if (quiet || $urandom_range(0, 2) != 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words under the reset settings: coincident bodies, zero
        // separation on one axis, the widest separations and mass extremes.
        send_pair(32'd5, 32'd7, 32'hFFFF_FFFF, 32'd5, 32'd7, 32'hFFFF_FFFF);
        send_pair(32'h8000_0000, 32'h8000_0000, 32'd0, 32'h8000_0000, 32'h8000_0000, 32'd0);
        send_pair(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'hFFFF_FFFF);
        send_pair(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
        send_pair(32'd10, 32'd10, 32'd0, 32'd11, 32'd9, 32'hFFFF_FFFF);
        send_pair(32'd3, 32'd3, 32'd1000, 32'd0, 32'd3, 32'd1000);
        repeat (150) send_random;
        drain;

        // Largest G: saturation of one or both components. The receiver holds
        // off for a long stretch here so that the pipeline fills and stalls.
        write_reg(REG_GRAV, 32'hFFFF_FFFF);
        write_reg(REG_SHIFT, 32'd0);
        send_pair(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'hFFFF_FFFF);
        send_pair(32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        send_pair(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd2, 32'hFFFF_FFFF);
        send_pair(32'd9, 32'd9, 32'hFFFF_FFFF, 32'd9, 32'd9, 32'hFFFF_FFFF);
        hold_req = 1'b1;
        repeat (160) send_random;
        drain;

        // Largest shift.
        write_reg(REG_GRAV, $urandom);
        write_reg(REG_SHIFT, 32'd63);
        send_pair(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'hFFFF_FFFF);
        repeat (160) send_random;
        drain;

        // Zero G with random bits above the shift field, which must be ignored.
        write_reg(REG_GRAV, 32'd0);
        write_reg(REG_SHIFT, $urandom);
        send_pair(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'hFFFF_FFFF);
        repeat (160) send_random;
        drain;

        // Final phase without idling on either side.
        write_reg(REG_GRAV, $urandom);
        write_reg(REG_SHIFT, $urandom_range(0, 40));
        quiet = 1'b1;
        repeat (160) send_random;
        drain;

        if (errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("testbench failed");
        $finish;
    end
endmodule

// File: files.f
rtl/gpf_pkg.sv
rtl/gpf_mul.sv
rtl/gravity_pair_force.sv
sim/gpf_checker.sv
sim/testbench.sv
